// ----- rtl/quadratic_root_solver_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// expression holds at every edge
`define QRS_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define QRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, types and constants shared by the quadratic root solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 33;

  // discriminant b*b - 4ac and its magnitude
  localparam int DISC_W = 2 * COEF_WIDTH + 2;
  localparam int DMAG_W = 2 * COEF_WIDTH + 1;

  // radicand |D| << 2*FRAC_BITS, padded to an even width
  localparam int RAD_W0 = DMAG_W + 2 * FRAC_BITS;
  localparam int RAD_W  = RAD_W0 + RAD_W0 % 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  // -b << FRAC_BITS, numerators and 2a
  localparam int NB_W  = COEF_WIDTH + FRAC_BITS + 1;
  localparam int NUM_W = ((NB_W > ROOT_W + 1) ? NB_W : ROOT_W + 1) + 1;
  localparam int DEN_W = COEF_WIDTH + 1;
  localparam int SAT_W = (NUM_W + 1 > OUT_W + 1) ? NUM_W + 1 : OUT_W + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int IN_DATA_W  = ((3 * COEF_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;
  localparam int USER_CPLX  = 0;
  localparam int USER_FAULT = 1;

  typedef struct packed {
    logic                     fault;
    logic signed [DISC_W-1:0] disc;
    logic signed [NB_W-1:0]   nb;
    logic signed [DEN_W-1:0]  den;
  } qrs_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] root_one;
    logic [OUT_W-1:0] root_two;
    logic [OUT_W-1:0] imag_part;
    logic             is_complex;
    logic             divide_fault;
  } qrs_result_t;

endpackage

// ----- rtl/qrs_front.sv -----
// ----------------------------------------------------------------------------
// qrs_front
// Two-stage front end: products and fault classification, then discriminant.
// ----------------------------------------------------------------------------
module qrs_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_a,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_b,
  input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_c,
  input  logic                                   q_full,
  output logic                                   push,
  output qrs_pkg::qrs_item_t                     push_item
);

  localparam int PW = 2 * qrs_pkg::COEF_WIDTH;

  logic                                f1_valid_r, f2_valid_r;
  logic signed [PW-1:0]                bb_r, ac_r;
  logic signed [qrs_pkg::NB_W-1:0]     nb_r;
  logic signed [qrs_pkg::DEN_W-1:0]    den_r;
  logic                                fault_r;
  qrs_pkg::qrs_item_t                  item_r, item_nxt;
  logic                                fen;
  logic signed [qrs_pkg::NB_W-1:0]     b_ext;
  logic signed [qrs_pkg::DISC_W-1:0]   bb_ext, ac_ext;

  assign fen      = !f2_valid_r || !q_full;
  assign in_ready = fen;
  assign push     = f2_valid_r && !q_full;
  assign push_item = item_r;

  assign b_ext = qrs_pkg::NB_W'(coef_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (fen) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      bb_r    <= coef_b * coef_b;
      ac_r    <= coef_a * coef_c;
      nb_r    <= -(b_ext <<< qrs_pkg::FRAC_BITS);
      den_r   <= {coef_a, 1'b0};
      fault_r <= (coef_a == '0);
      item_r  <= item_nxt;
    end
  end

  assign bb_ext = qrs_pkg::DISC_W'(bb_r);
  assign ac_ext = qrs_pkg::DISC_W'(ac_r);

  always_comb begin
    item_nxt.fault = fault_r;
    item_nxt.disc  = bb_ext - (ac_ext <<< 2);
    item_nxt.nb    = nb_r;
    item_nxt.den   = den_r;
  end

endmodule

// ----- rtl/qrs_queue.sv -----
// ----------------------------------------------------------------------------
// qrs_queue
// Short FIFO between the front end and the root/divide pipeline.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_macros.svh"

module qrs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qrs_pkg::qrs_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output qrs_pkg::qrs_item_t head_item
);

  qrs_pkg::qrs_item_t              mem_r [qrs_pkg::Q_DEPTH];
  logic [qrs_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [qrs_pkg::Q_CNT_W-1:0]     cnt_r, cnt_nxt;

  localparam logic [qrs_pkg::Q_PTR_W-1:0] LAST = qrs_pkg::Q_PTR_W'(qrs_pkg::Q_DEPTH - 1);
  localparam logic [qrs_pkg::Q_CNT_W-1:0] FULL = qrs_pkg::Q_CNT_W'(qrs_pkg::Q_DEPTH);

  assign full       = (cnt_r == FULL);
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  `QRS_ASSERT(a_cnt_range, cnt_r <= FULL, "queue count beyond depth")
  `QRS_ASSERT_IMPL(a_no_overflow, push, !full || pop, "push into full queue")
  `QRS_ASSERT_IMPL(a_no_underflow, pop, cnt_r != '0, "pop from empty queue")

endmodule

// ----- rtl/qrs_back.sv -----
// ----------------------------------------------------------------------------
// qrs_back
// Pipelined square root, two pipelined dividers and the saturating output.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_macros.svh"

module qrs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  qrs_pkg::qrs_item_t   q_item,
  output logic                 q_pop,
  input  logic                 out_ready,
  output logic                 out_valid,
  output qrs_pkg::qrs_result_t out_result
);

  localparam int RW  = qrs_pkg::ROOT_W;
  localparam int NW  = qrs_pkg::NUM_W;
  localparam int DW  = qrs_pkg::DEN_W;
  localparam int SW  = qrs_pkg::SAT_W;
  localparam int OW  = qrs_pkg::OUT_W;

  typedef struct packed {
    logic                            fault;
    logic                            cplx;
    logic signed [qrs_pkg::NB_W-1:0] nb;
    logic signed [DW-1:0]            den;
  } sq_side_t;

  typedef struct packed {
    logic          fault;
    logic          cplx;
    logic [1:0]    neg;
    logic [DW-1:0] dmag;
  } dv_side_t;

  logic adv;
  logic out_valid_r;
  qrs_pkg::qrs_result_t res_r, res_nxt;

  assign adv        = !out_valid_r || out_ready;
  assign q_pop      = adv && q_valid;
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  // ---- prep: |D| and radicand
  logic [RW:0]                    sv_r;
  logic [qrs_pkg::RAD_W-1:0]      rad_r  [RW+1];
  logic [qrs_pkg::REM_W-1:0]      rem_r  [RW+1];
  logic [RW-1:0]                  rt_r   [RW+1];
  sq_side_t                       sq_r   [RW+1];
  logic signed [qrs_pkg::DISC_W-1:0] neg_disc;
  logic [qrs_pkg::DMAG_W-1:0]     dmag;

  assign neg_disc = -q_item.disc;
  assign dmag = q_item.disc[qrs_pkg::DISC_W-1] ? neg_disc[qrs_pkg::DMAG_W-1:0]
                                               : q_item.disc[qrs_pkg::DMAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else if (adv) sv_r[0] <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r[0]       <= qrs_pkg::RAD_W'(dmag) << (2 * qrs_pkg::FRAC_BITS);
      rem_r[0]       <= '0;
      rt_r[0]        <= '0;
      sq_r[0].fault  <= q_item.fault;
      sq_r[0].cplx   <= q_item.disc[qrs_pkg::DISC_W-1];
      sq_r[0].nb     <= q_item.nb;
      sq_r[0].den    <= q_item.den;
    end
  end

  // ---- restoring square root, one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [qrs_pkg::REM_W-1:0] rem_sh, trial;
    logic                      ge;
    assign rem_sh = {rem_r[k][qrs_pkg::REM_W-3:0], rad_r[k][qrs_pkg::RAD_W-1 -: 2]};
    assign trial  = qrs_pkg::REM_W'({rt_r[k], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k+1] <= 1'b0;
      else if (adv) sv_r[k+1] <= sv_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k+1] <= rad_r[k] << 2;
        rem_r[k+1] <= ge ? rem_sh - trial : rem_sh;
        rt_r[k+1]  <= {rt_r[k][RW-2:0], ge};
        sq_r[k+1]  <= sq_r[k];
      end
    end
  end

  // ---- numerators: real -> nb+s, nb-s ; complex -> nb, s
  logic                 nv_r;
  logic signed [NW-1:0] n1_r, n2_r;
  sq_side_t             ns_r;
  logic signed [NW-1:0] s_ext, nb_ext;

  assign s_ext  = NW'(rt_r[RW]);
  assign nb_ext = NW'(sq_r[RW].nb);

  always_ff @(posedge clk) begin
    if (!rst_n) nv_r <= 1'b0;
    else if (adv) nv_r <= sv_r[RW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r <= sq_r[RW].cplx ? nb_ext : nb_ext + s_ext;
      n2_r <= sq_r[RW].cplx ? s_ext  : nb_ext - s_ext;
      ns_r <= sq_r[RW];
    end
  end

  // ---- magnitudes and quotient signs
  logic [NW:0]          dv_r;
  logic [NW-1:0]        m_r  [NW+1][2];
  logic [DW-1:0]        r_r  [NW+1][2];
  dv_side_t             ds_r [NW+1];
  logic signed [NW-1:0] n1_neg, n2_neg;
  logic signed [DW-1:0] den_neg;

  assign n1_neg  = -n1_r;
  assign n2_neg  = -n2_r;
  assign den_neg = -ns_r.den;

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (adv) dv_r[0] <= nv_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0][0]     <= n1_r[NW-1] ? n1_neg : n1_r;
      m_r[0][1]     <= n2_r[NW-1] ? n2_neg : n2_r;
      r_r[0][0]     <= '0;
      r_r[0][1]     <= '0;
      ds_r[0].fault <= ns_r.fault;
      ds_r[0].cplx  <= ns_r.cplx;
      ds_r[0].neg   <= {n2_r[NW-1] ^ ns_r.den[DW-1], n1_r[NW-1] ^ ns_r.den[DW-1]};
      ds_r[0].dmag  <= ns_r.den[DW-1] ? den_neg : ns_r.den;
    end
  end

  // ---- restoring division, one quotient bit per stage, two lanes
  for (genvar j = 0; j < NW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else if (adv) dv_r[j+1] <= dv_r[j];
    end

    always_ff @(posedge clk) begin
      if (adv) ds_r[j+1] <= ds_r[j];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] r_sh, d_ext, r_dif;
      logic        ge;
      assign r_sh  = {r_r[j][l], m_r[j][l][NW-1]};
      assign d_ext = {1'b0, ds_r[j].dmag};
      assign r_dif = r_sh - d_ext;
      assign ge    = r_sh >= d_ext;

      always_ff @(posedge clk) begin
        if (adv) begin
          r_r[j+1][l] <= ge ? r_dif[DW-1:0] : r_sh[DW-1:0];
          m_r[j+1][l] <= {m_r[j][l][NW-2:0], ge};
        end
      end
    end
  end

  // ---- sign, saturate, pack
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW-OW+1){1'b1}}, {(OW-1){1'b0}}};

  logic signed [SW-1:0] qv  [2];
  logic signed [SW-1:0] qs  [2];
  logic [OW-1:0]        sat [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qv[l] = signed'(SW'(m_r[NW][l]));
      qs[l] = ds_r[NW].neg[l] ? -qv[l] : qv[l];
      if (qs[l] > SAT_MAX)      sat[l] = SAT_MAX[OW-1:0];
      else if (qs[l] < SAT_MIN) sat[l] = SAT_MIN[OW-1:0];
      else                      sat[l] = qs[l][OW-1:0];
    end
    res_nxt.divide_fault = ds_r[NW].fault;
    if (ds_r[NW].fault) begin
      res_nxt.root_one   = '0;
      res_nxt.root_two   = '0;
      res_nxt.imag_part  = '0;
      res_nxt.is_complex = 1'b0;
    end else if (ds_r[NW].cplx) begin
      res_nxt.root_one   = sat[0];
      res_nxt.root_two   = sat[0];
      res_nxt.imag_part  = sat[1];
      res_nxt.is_complex = 1'b1;
    end else begin
      res_nxt.root_one   = sat[0];
      res_nxt.root_two   = sat[1];
      res_nxt.imag_part  = '0;
      res_nxt.is_complex = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_r[NW];
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end

  `QRS_ASSERT_IMPL(a_fault_zero, out_valid_r && res_r.divide_fault,
    res_r.root_one == '0 && res_r.root_two == '0 && res_r.imag_part == '0 && !res_r.is_complex,
    "fault result carries nonzero fields")
  `QRS_ASSERT_NEXT(a_pop_enters, q_pop, sv_r[0], "popped item missing from pipeline")

endmodule

// ----- rtl/quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c = 0 in fixed point with 16 fraction bits.
//
//   channel  dir  signals                          beat carries
//   in_      in   in_tvalid/in_tready/in_tdata     coef_a, coef_b, coef_c
//   out_     out  out_tvalid/out_tready/out_tdata  roots, imag part, flags
//
// Throughput one beat per clock while out_tready does not hold the output;
// the root and divide pipes compute one bit per stage.
// rst_n clears only valid and queue control; payload registers are not reset.
// An output stall freezes the back pipe; the front keeps filling the 4-entry
// queue and drops in_tready only once that queue is full and the second front
// stage holds a beat.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
  input  logic [qrs_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [32:0] root_one, [65:33] root_two, [98:66] imag_part, rest zero
  output logic [qrs_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] is_complex, [1] divide_fault
  output logic [qrs_pkg::OUT_USER_W-1:0]     out_tuser
);

  localparam int CW = qrs_pkg::COEF_WIDTH;
  localparam int OW = qrs_pkg::OUT_W;

  logic                 q_full, push, q_pop, q_valid;
  qrs_pkg::qrs_item_t   push_item, head_item;
  qrs_pkg::qrs_result_t result;

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .coef_a    (in_tdata[CW-1:0]),
    .coef_b    (in_tdata[2*CW-1:CW]),
    .coef_c    (in_tdata[3*CW-1:2*CW]),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  qrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  qrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_result (result)
  );

  assign out_tdata = qrs_pkg::OUT_DATA_W'({result.imag_part, result.root_two, result.root_one});
  always_comb begin
    out_tuser = '0;
    out_tuser[qrs_pkg::USER_CPLX]  = result.is_complex;
    out_tuser[qrs_pkg::USER_FAULT] = result.divide_fault;
  end

endmodule

// ----- test/qrs_checker.sv -----
// ----------------------------------------------------------------------------
// qrs_checker
// Watches both channels of the quadratic root solver. Each coefficient beat
// is turned into a predicted result, and each result beat is compared field
// by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module qrs_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [qrs_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [qrs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [qrs_pkg::OUT_USER_W-1:0] out_tuser,
  output int                            fail_count,
  output int                            pending
);
  import qrs_pkg::*;

  qrs_result_t roots_due[$];

  // floor(sqrt(x * 2^(2*FRAC_BITS))), bit-serial restoring root
  function automatic logic [127:0] root_scaled(logic [63:0] x);
    logic [127:0] rem;
    logic [127:0] rt;
    logic [127:0] trial;
    rem = '0;
    rt  = '0;
    for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
      rem = rem << 2;
      if (i >= FRAC_BITS) rem = rem | ((x >> (2 * (i - FRAC_BITS))) & 64'd3);
      trial = (rt << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        rt  = (rt << 1) | 128'd1;
      end else begin
        rt = rt << 1;
      end
    end
    return rt;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(longint v);
    if (v > 64'sd4294967295) v = 64'sd4294967295;
    if (v < -64'sd4294967296) v = -64'sd4294967296;
    return v[OUT_W-1:0];
  endfunction

  function automatic qrs_result_t solve_roots(logic [IN_DATA_W-1:0] d);
    qrs_result_t r;
    longint a, b, c, disc, den, nb, s, re;
    a = longint'($signed(d[COEF_WIDTH-1:0]));
    b = longint'($signed(d[2*COEF_WIDTH-1:COEF_WIDTH]));
    c = longint'($signed(d[3*COEF_WIDTH-1:2*COEF_WIDTH]));
    r = '0;
    if (a == 0) begin
      r.divide_fault = 1'b1;
      return r;
    end
    disc = b * b - 4 * a * c;
    den  = 2 * a;
    nb   = -b * (longint'(1) <<< FRAC_BITS);
    if (disc >= 0) begin
      s = longint'(root_scaled(disc));
      r.root_one = clamp_out((nb + s) / den);
      r.root_two = clamp_out((nb - s) / den);
    end else begin
      s  = longint'(root_scaled(-disc));
      re = nb / den;
      r.root_one   = clamp_out(re);
      r.root_two   = clamp_out(re);
      r.imag_part  = clamp_out(s / den);
      r.is_complex = 1'b1;
    end
    return r;
  endfunction

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    qrs_result_t want;
    qrs_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) roots_due.push_back(solve_roots(in_tdata));
      if (out_tvalid && out_tready) begin
        got.root_one     = out_tdata[OUT_W-1:0];
        got.root_two     = out_tdata[2*OUT_W-1:OUT_W];
        got.imag_part    = out_tdata[3*OUT_W-1:2*OUT_W];
        got.is_complex   = out_tuser[USER_CPLX];
        got.divide_fault = out_tuser[USER_FAULT];
        if (roots_due.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = roots_due.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.root_one != want.root_one)
              $error("root_one exp %h got %h", want.root_one, got.root_one);
            if (got.root_two != want.root_two)
              $error("root_two exp %h got %h", want.root_two, got.root_two);
            if (got.imag_part != want.imag_part)
              $error("imag_part exp %h got %h", want.imag_part, got.imag_part);
            if (got.is_complex != want.is_complex)
              $error("is_complex exp %0d got %0d", want.is_complex, got.is_complex);
            if (got.divide_fault != want.divide_fault)
              $error("divide_fault exp %0d got %0d", want.divide_fault,
                     got.divide_fault);
          end
        end
      end
    end
    pending <= roots_due.size();
  end
endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives coefficient sets into the quadratic root solver: a directed set of
// corner cases, then random sets in bursts, with the result side stalling
// on its own pattern and at times for a long stretch. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import qrs_pkg::*;

  localparam int N_RANDOM = 1500;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [OUT_USER_W-1:0]  out_tuser;
  int                     fail_count;
  int                     pending;

  quadratic_root_solver u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  qrs_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // hold valid until the beat goes through; valid stays high afterwards
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    in_tvalid <= 1'b1;
    in_tdata  <= {c, b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_cycles(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return 16'($signed($urandom_range(0, 16)) - 8);
      1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      2:       return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: changing stall patterns, long hold-offs
  initial begin
    int mode;
    out_tready <= 1'b0;
    @(posedge rst_n);
    // early hold-off while the sender is still busy: fills the block
    repeat (40) begin
      @(posedge clk);
      out_tready <= 1'b1;
    end
    out_tready <= 1'b0;
    repeat (300) @(posedge clk);
    repeat (1500) begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 80)) begin
        @(posedge clk);
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= $urandom_range(0, 1);
        endcase
      end
      if (mode == 3 && $urandom_range(0, 20) == 0) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
    @(posedge clk);
    out_tready <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int gap;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: zero a, zero and negative discriminant, sign extremes
    send_coefs(16'd0, 16'd5, 16'd3);
    send_coefs(16'd0, 16'h8000, 16'h7fff);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'd1, 16'd0, 16'd1);
    send_coefs(16'd1, 16'd0, 16'hffff);
    send_coefs(16'hffff, 16'd0, 16'hffff);
    send_coefs(16'hffff, 16'd3, 16'd7);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'd1, 16'h8000, 16'h8000);
    send_coefs(16'd1, 16'h7fff, 16'h8000);
    send_coefs(16'hffff, 16'h8000, 16'h7fff);
    send_coefs(16'd1, 16'd0, 16'd0);
    send_coefs(16'd2, 16'd4, 16'd2);
    send_coefs(16'hfffe, 16'hfffc, 16'hfffe);
    send_coefs(16'd3, 16'd1, 16'd5);
    idle_cycles(3);

    for (int i = 0; i < N_RANDOM; i++) begin
      send_coefs(rand_coef(), rand_coef(), rand_coef());
      if ($urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 12);
        idle_cycles(gap);
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_front.sv
rtl/qrs_queue.sv
rtl/qrs_back.sv
rtl/quadratic_root_solver.sv
test/qrs_checker.sv
test/tb.sv
